>>> src/dmv_pkg.sv
// ----------------------------------------------------------------------------
// dmv_pkg
// Shared types, sizes and helpers of the dense matrix-vector multiplier.
// ----------------------------------------------------------------------------
package dmv_pkg;

  // Field widths
  localparam int unsigned ACT_W = 2;
  localparam int unsigned ROW_W = 6;
  localparam int unsigned COL_W = 6;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned CFG_W = 7;
  localparam int unsigned FRAC_W = 16;

  // Store geometry
  localparam int unsigned MAX_ROWS = 64;
  localparam int unsigned MAX_COLS = 64;
  localparam int unsigned COL_LIMIT = (MAX_COLS < (2 ** COL_W)) ? MAX_COLS : (2 ** COL_W);
  localparam int unsigned MAT_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int unsigned MAT_AW = $clog2(MAT_DEPTH);
  localparam int unsigned VEC_AW = $clog2(MAX_COLS);

  // Accumulator: exact sum of COL_LIMIT full products
  localparam int unsigned PROD_W = 2 * VAL_W;
  localparam int unsigned ACC_W = PROD_W + $clog2(COL_LIMIT) + 1;
  localparam int unsigned SAT_LO = FRAC_W + VAL_W - 1;

  localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W - 1){1'b1}}};
  localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W - 1){1'b0}}};

  // Queues
  localparam int unsigned CMDQ_DEPTH = 4;
  localparam int unsigned CMDQ_AW = $clog2(CMDQ_DEPTH);
  localparam int unsigned RESQ_DEPTH = 8;
  localparam int unsigned RESQ_AW = $clog2(RESQ_DEPTH);

  // Configuration port
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  typedef enum logic [ACT_W-1:0] {
    ACT_WR_MAT  = 2'd0,
    ACT_WR_VEC  = 2'd1,
    ACT_COMPUTE = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    OP_WR_MAT,
    OP_WR_VEC,
    OP_COMPUTE
  } op_e;

  typedef enum logic {
    REG_ROWS = 1'b0,
    REG_COLS = 1'b1
  } reg_e;

  typedef struct packed {
    logic [ACT_W-1:0]        action;
    logic [ROW_W-1:0]        row;
    logic [COL_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [ROW_W-1:0]        row_index;
    logic signed [VAL_W-1:0] result_value;
    logic                    last;
  } out_item_t;

  typedef struct packed {
    op_e              op;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [VAL_W-1:0] value;
  } cmd_t;

  // Command queue handshake toward the back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_chan_t;

  // Result queue handshake from the back end
  typedef struct packed {
    logic      push;
    out_item_t item;
  } res_chan_t;

  // Clamp a count register to 1..limit and return count - 1
  function automatic logic [CFG_W-1:0] last_index(input logic [CFG_W-1:0] n,
                                                  input logic [CFG_W-1:0] limit);
    logic [CFG_W-1:0] r;
    if (n == '0) begin
      r = '0;
    end else if (n > limit) begin
      r = limit - CFG_W'(1);
    end else begin
      r = n - CFG_W'(1);
    end
    return r;
  endfunction

endpackage

>>> src/dmv_ram.sv
// ----------------------------------------------------------------------------
// dmv_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module dmv_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/dmv_front.sv
// ----------------------------------------------------------------------------
// dmv_front
// Accepts input transactions, decodes the action and queues commands.
// ----------------------------------------------------------------------------
module dmv_front
  import dmv_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  output logic      full_o,
  input  in_item_t  item_i,
  output cmd_chan_t cmd_o,
  input  logic      cmd_pop_i
);

  cmd_t               mem_q [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CMDQ_AW:0]   count_q;
  logic               keep;
  op_e                op;
  logic               enq, deq;

  // Unknown action codes are consumed and dropped
  always_comb begin
    keep = 1'b1;
    op   = OP_WR_MAT;
    case (item_i.action)
      ACT_WR_MAT:  op = OP_WR_MAT;
      ACT_WR_VEC:  op = OP_WR_VEC;
      ACT_COMPUTE: op = OP_COMPUTE;
      default:     keep = 1'b0;
    endcase
  end

  assign full_o    = (count_q == (CMDQ_AW + 1)'(CMDQ_DEPTH));
  assign enq       = push_i && !full_o && keep;
  assign deq       = cmd_pop_i && cmd_o.valid;
  assign cmd_o.valid = (count_q != '0);
  assign cmd_o.cmd   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (enq) begin
        wr_ptr_q <= wr_ptr_q + CMDQ_AW'(1);
      end
      if (deq) begin
        rd_ptr_q <= rd_ptr_q + CMDQ_AW'(1);
      end
      if (enq && !deq) begin
        count_q <= count_q + (CMDQ_AW + 1)'(1);
      end else if (deq && !enq) begin
        count_q <= count_q - (CMDQ_AW + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) begin
      mem_q[wr_ptr_q] <= '{op: op, row: item_i.row, col: item_i.col,
                           value: item_i.value};
    end
  end

endmodule

>>> src/dmv_resq.sv
// ----------------------------------------------------------------------------
// dmv_resq
// Result queue; the head entry drives the result port.
// ----------------------------------------------------------------------------
module dmv_resq
  import dmv_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  res_chan_t        res_i,
  output logic [RESQ_AW:0] count_o,
  input  logic             pop_i,
  output logic             empty_o,
  output out_item_t        item_o
);

  out_item_t          mem_q [RESQ_DEPTH];
  logic [RESQ_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [RESQ_AW:0]   count_q;
  logic               deq;

  assign empty_o = (count_q == '0);
  assign deq     = pop_i && !empty_o;
  assign item_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;

  // The back end only pushes when it holds a free slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (res_i.push) begin
        wr_ptr_q <= wr_ptr_q + RESQ_AW'(1);
      end
      if (deq) begin
        rd_ptr_q <= rd_ptr_q + RESQ_AW'(1);
      end
      if (res_i.push && !deq) begin
        count_q <= count_q + (RESQ_AW + 1)'(1);
      end else if (deq && !res_i.push) begin
        count_q <= count_q - (RESQ_AW + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_i.push) begin
      mem_q[wr_ptr_q] <= res_i.item;
    end
  end

endmodule

>>> src/dmv_back.sv
// ----------------------------------------------------------------------------
// dmv_back
// Executes queued commands: store writes and the row-by-column MAC walk.
// ----------------------------------------------------------------------------
module dmv_back
  import dmv_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_chan_t        cmd_i,
  output logic             cmd_pop_o,
  input  logic [CFG_W-1:0] rows_cfg_i,
  input  logic [CFG_W-1:0] cols_cfg_i,
  input  logic [RESQ_AW:0] res_count_i,
  output res_chan_t        res_o
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e           state_q;
  logic [ROW_W-1:0] row_q, rmax_q;
  logic [COL_W-1:0] col_q, cmax_q;
  logic [CFG_W-1:0] rmax_d, cmax_d;
  logic [RESQ_AW:0] inflight_q, inflight_d;

  logic mat_we, vec_we;
  logic [VAL_W-1:0] mat_rdata, vec_rdata;
  logic credit_ok, issue, row_start, col_end, row_end;

  // Pipeline: s1 = store read, s2 = product, s3 = row sum done
  logic                    s1_valid_q, s1_first_q, s1_last_col_q, s1_final_q;
  logic [ROW_W-1:0]        s1_row_q;
  logic                    s2_valid_q, s2_first_q, s2_last_col_q, s2_final_q;
  logic [ROW_W-1:0]        s2_row_q;
  logic signed [PROD_W-1:0] prod_q;
  logic                    s3_done_q, s3_final_q;
  logic [ROW_W-1:0]        s3_row_q;
  logic [ACC_W-1:0]        acc_q, acc_base, prod_ext;
  logic                    sat_over, sat_under;
  logic [VAL_W-1:0]        sat_value;

  assign cmd_pop_o = (state_q == ST_IDLE) && cmd_i.valid;
  assign mat_we    = cmd_pop_o && (cmd_i.cmd.op == OP_WR_MAT);
  assign vec_we    = cmd_pop_o && (cmd_i.cmd.op == OP_WR_VEC);

  assign rmax_d = last_index(rows_cfg_i, CFG_W'(MAX_ROWS));
  assign cmax_d = last_index(cols_cfg_i, CFG_W'(COL_LIMIT));

  // A row starts only if its result has a reserved queue slot
  assign credit_ok = ((RESQ_AW + 2)'(res_count_i) + (RESQ_AW + 2)'(inflight_q))
                     < (RESQ_AW + 2)'(RESQ_DEPTH);
  assign issue     = (state_q == ST_RUN) && ((col_q != '0) || credit_ok);
  assign row_start = issue && (col_q == '0);
  assign col_end   = (col_q == cmax_q);
  assign row_end   = (row_q == rmax_q);

  always_comb begin
    inflight_d = inflight_q;
    case ({row_start, res_o.push})
      2'b10:   inflight_d = inflight_q + (RESQ_AW + 1)'(1);
      2'b01:   inflight_d = inflight_q - (RESQ_AW + 1)'(1);
      default: inflight_d = inflight_q;
    endcase
  end

  dmv_ram #(
    .WIDTH(VAL_W),
    .DEPTH(MAT_DEPTH)
  ) u_mat_ram (
    .clk_i  (clk_i),
    .we_i   (mat_we),
    .waddr_i(MAT_AW'({cmd_i.cmd.row, cmd_i.cmd.col})),
    .wdata_i(cmd_i.cmd.value),
    .raddr_i(MAT_AW'({row_q, col_q})),
    .rdata_o(mat_rdata)
  );

  dmv_ram #(
    .WIDTH(VAL_W),
    .DEPTH(MAX_COLS)
  ) u_vec_ram (
    .clk_i  (clk_i),
    .we_i   (vec_we),
    .waddr_i(VEC_AW'(cmd_i.cmd.col)),
    .wdata_i(cmd_i.cmd.value),
    .raddr_i(VEC_AW'(col_q)),
    .rdata_o(vec_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      row_q      <= '0;
      col_q      <= '0;
      rmax_q     <= '0;
      cmax_q     <= '0;
      inflight_q <= '0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_done_q  <= 1'b0;
    end else begin
      inflight_q <= inflight_d;
      s1_valid_q <= issue;
      s2_valid_q <= s1_valid_q;
      s3_done_q  <= s2_valid_q && s2_last_col_q;
      case (state_q)
        ST_IDLE: begin
          if (cmd_pop_o && (cmd_i.cmd.op == OP_COMPUTE)) begin
            state_q <= ST_RUN;
            row_q   <= '0;
            col_q   <= '0;
            rmax_q  <= rmax_d[ROW_W-1:0];
            cmax_q  <= cmax_d[COL_W-1:0];
          end
        end
        ST_RUN: begin
          if (issue) begin
            if (col_end) begin
              col_q <= '0;
              if (row_end) begin
                state_q <= ST_IDLE;
              end else begin
                row_q <= row_q + ROW_W'(1);
              end
            end else begin
              col_q <= col_q + COL_W'(1);
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign prod_ext = {{(ACC_W - PROD_W){prod_q[PROD_W-1]}}, prod_q};
  assign acc_base = s2_first_q ? '0 : acc_q;

  always_ff @(posedge clk_i) begin
    s1_first_q    <= (col_q == '0);
    s1_last_col_q <= col_end;
    s1_final_q    <= row_end;
    s1_row_q      <= row_q;
    prod_q        <= $signed(mat_rdata) * $signed(vec_rdata);
    s2_first_q    <= s1_first_q;
    s2_last_col_q <= s1_last_col_q;
    s2_final_q    <= s1_final_q;
    s2_row_q      <= s1_row_q;
    if (s2_valid_q) begin
      acc_q      <= acc_base + prod_ext;
      s3_row_q   <= s2_row_q;
      s3_final_q <= s2_final_q;
    end
  end

  // Floor shift by FRAC_W and saturate
  assign sat_over  = !acc_q[ACC_W-1] && (|acc_q[ACC_W-2:SAT_LO]);
  assign sat_under = acc_q[ACC_W-1] && !(&acc_q[ACC_W-2:SAT_LO]);
  assign sat_value = sat_over  ? VAL_MAX :
                     sat_under ? VAL_MIN : acc_q[FRAC_W+VAL_W-1:FRAC_W];

  assign res_o.push              = s3_done_q;
  assign res_o.item.row_index    = s3_row_q;
  assign res_o.item.result_value = sat_value;
  assign res_o.item.last         = s3_final_q;

endmodule

>>> src/dense_matrix_vector_multiply.sv
// Load transactions: one per cycle while the back end idles; queued, stored when popped.
// Compute: one multiply-accumulate per cycle, unless a row start waits for credit, through the single
//   MAC unit and its matrix RAM read port.
// Results are credited against the 8-entry result queue, so the walk pauses when
//   results are not popped.
// Reset: queues empty, rows_in_use and cols_in_use = 64; stores are not cleared.
// ----------------------------------------------------------------------------
// dense_matrix_vector_multiply
// y = A * x in signed Q16.16, with a decoupled command front and MAC back end.
// ----------------------------------------------------------------------------
module dense_matrix_vector_multiply
  import dmv_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // Input queue side
  input  logic              push,
  output logic              full,
  input  in_item_t          in_item_i,
  // Result queue side
  input  logic              pop,
  output logic              empty,
  output out_item_t         out_item_o,
  // Configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  // Configuration registers, 4-byte stride: paddr[2] selects the register
  logic [CFG_W-1:0] rows_q, cols_q;
  logic             cfg_wr;
  reg_e             cfg_sel;

  cmd_chan_t        cmd;
  logic             cmd_pop;
  res_chan_t        res;
  logic [RESQ_AW:0] res_count;

  assign pready  = 1'b1;
  assign cfg_sel = reg_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= CFG_W'(MAX_ROWS);
      cols_q <= CFG_W'(MAX_COLS);
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_ROWS: rows_q <= pwdata[CFG_W-1:0];
        REG_COLS: cols_q <= pwdata[CFG_W-1:0];
        default:  rows_q <= rows_q;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (cfg_sel)
      REG_ROWS: prdata[CFG_W-1:0] = rows_q;
      REG_COLS: prdata[CFG_W-1:0] = cols_q;
      default:  prdata = '0;
    endcase
  end

  // Front: takes input transactions while not full, drops unknown actions
  dmv_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .full_o   (full),
    .item_i   (in_item_i),
    .cmd_o    (cmd),
    .cmd_pop_i(cmd_pop)
  );

  // Back: performs store writes; compute walks rows x cols on one MAC
  dmv_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cmd_pop_o  (cmd_pop),
    .rows_cfg_i (rows_q),
    .cols_cfg_i (cols_q),
    .res_count_i(res_count),
    .res_o      (res)
  );

  // Result queue decouples the MAC from the consumer
  dmv_resq u_resq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .res_i  (res),
    .count_o(res_count),
    .pop_i  (pop),
    .empty_o(empty),
    .item_o (out_item_o)
  );

endmodule

>>> src/dmv_checker.sv
// ----------------------------------------------------------------------------
// dmv_checker
// Port-level checks of the dense matrix-vector multiplier.
// ----------------------------------------------------------------------------
module dmv_checker
  import dmv_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              pop,
  input logic              empty,
  input out_item_t         out_item_o,
  input logic              psel,
  input logic              penable,
  input logic              pwrite,
  input logic [APB_AW-1:0] paddr,
  input logic [APB_DW-1:0] pwdata,
  input logic [APB_DW-1:0] prdata,
  input logic              pready
);

  logic [ROW_W-1:0] exp_row_q;
  logic             res_take;

  assign res_take = pop && !empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_row_q <= '0;
    end else if (res_take) begin
      exp_row_q <= out_item_o.last ? '0 : out_item_o.row_index + ROW_W'(1);
    end
  end

  // Results of one compute come out in ascending row order from row 0
  a_row_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_take |-> out_item_o.row_index == exp_row_q)
    else $error("result row out of sequence");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_item_o)))
    else $error("waiting result changed or vanished");

  a_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && pready) ##1
    (psel && !pwrite && (paddr[2] == $past(paddr[2])))
    |-> prdata[CFG_W-1:0] == $past(pwdata[CFG_W-1:0]))
    else $error("config readback mismatch");

  a_rd_upper: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && !pwrite) |-> prdata[APB_DW-1:CFG_W] == '0)
    else $error("config read upper bits not zero");

endmodule

bind dense_matrix_vector_multiply dmv_checker u_checker (.*);
